[sv/osm_pkg.sv]
// Package for the order statistic multiset: types, widths and codes.
package osm_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;

    // Flipping the sign bit makes unsigned order equal signed order.
    localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_KTH    = 2'd2;
    localparam logic [1:0] OP_RANK   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;
    localparam logic [1:0] STAT_RANGE  = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] kth_value;
        logic [POS_W-1:0]        count_below;
        logic [POS_W-1:0]        count_at_or_below;
        logic [POS_W-1:0]        occupancy;
    } rsp_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic             eval;
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] key;
        logic [IDX_W-1:0] sel;
    } cell_cmd_t;

    // What a cell shows to its neighbors and to the top level.
    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             valid;
        logic             le;
        logic             lt;
        logic [VAL_W-1:0] kpart;
    } cell_state_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

endpackage

[sv/order_statistic_multiset.sv]
// Top level of the order statistic multiset: control, counts and the cell chain.
//
//   channel  ports                      payload
//   request  s_valid s_ready s_data     req_t: operation, value, position
//   result   m_valid m_ready m_data     rsp_t: status, kth_value, counts, occupancy
//
// As a request is taken, every cell compares its entry with the key; in the
// evaluation state the counts are encoded from the cell flags and the chain
// shifts. A request is taken while a result still waits; the evaluation state
// holds until the output register is free. Reset empties the store at once.
// While a result waits, one more request is taken and held in its evaluation
// state; the input then stalls until the waiting result leaves.
module order_statistic_multiset (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  osm_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output osm_pkg::rsp_t  m_data
);
    import osm_pkg::*;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             m_valid_reg, m_valid_next;
    rsp_t             m_data_reg, m_data_next;

    cell_cmd_t        cmd;
    cell_state_t      cells [CAPACITY];
    cell_state_t      left_edge, right_edge;

    logic             s_fire, commit;
    logic [CNT_W-1:0] lt_cnt, le_cnt;
    logic [VAL_W-1:0] kth_raw;
    logic [WIDE_W-1:0] pos_w;
    logic             found, full, pos_bad;

    assign s_fire = s_valid && s_ready;
    assign commit = (state_reg == ST_EVAL) && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_EVAL;
            ST_EVAL: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and cell command by state.
    always_comb begin
        s_ready  = 1'b0;
        cmd.eval = 1'b0;
        cmd.ins  = 1'b0;
        cmd.del  = 1'b0;
        cmd.key  = req_reg.value ^ SIGN_FLIP;
        cmd.sel  = IDX_W'(pos_w - WIDE_W'(1));
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.eval = s_fire;
                cmd.key  = s_data.value ^ SIGN_FLIP;
                cmd.sel  = IDX_W'(WIDE_W'(s_data.position) - WIDE_W'(1));
            end
            ST_EVAL: begin
                cmd.ins = commit && (req_reg.operation == OP_INSERT) && !full;
                cmd.del = commit && (req_reg.operation == OP_ERASE) && found;
            end
            default: ;
        endcase
    end

    // Chain boundaries: the left edge always stays put, nothing lies to the right.
    always_comb begin
        left_edge       = '0;
        left_edge.valid = 1'b1;
        left_edge.le    = 1'b1;
        left_edge.lt    = 1'b1;
        right_edge      = '0;
    end

    // The cell chain.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        osm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .cell_idx (IDX_W'(i)),
            .left     ((i == 0) ? left_edge : cells[(i == 0) ? 0 : i - 1]),
            .right    ((i == CAPACITY - 1) ? right_edge
                                           : cells[(i == CAPACITY - 1) ? i : i + 1]),
            .state    (cells[i])
        );
    end

    // The flags form a prefix; encode where each prefix ends, and gather the kth entry.
    always_comb begin
        logic nxt_lt, nxt_le;
        lt_cnt  = '0;
        le_cnt  = '0;
        kth_raw = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            nxt_lt = (i == CAPACITY - 1) ? 1'b0 : cells[(i == CAPACITY - 1) ? i : i + 1].lt;
            nxt_le = (i == CAPACITY - 1) ? 1'b0 : cells[(i == CAPACITY - 1) ? i : i + 1].le;
            if (cells[i].lt && !nxt_lt) lt_cnt = lt_cnt | CNT_W'(i + 1);
            if (cells[i].le && !nxt_le) le_cnt = le_cnt | CNT_W'(i + 1);
            kth_raw = kth_raw | cells[i].kpart;
        end
    end

    // Result of the request under evaluation.
    always_comb begin
        pos_w   = WIDE_W'(req_reg.position);
        full    = (fill_reg == CNT_W'(CAPACITY));
        found   = (le_cnt != lt_cnt);
        pos_bad = (pos_w == '0) || (pos_w > WIDE_W'(fill_reg));

        req_next     = s_fire ? s_data : req_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (commit) begin
            m_valid_next                 = 1'b1;
            m_data_next.status           = STAT_OK;
            m_data_next.kth_value        = '0;
            m_data_next.count_below      = POS_W'(lt_cnt);
            m_data_next.count_at_or_below = POS_W'(le_cnt);
            case (req_reg.operation)
                OP_INSERT: begin
                    if (full) begin
                        m_data_next.status = STAT_FULL;
                    end else begin
                        fill_next = fill_reg + CNT_W'(1);
                        m_data_next.count_at_or_below = POS_W'(le_cnt + CNT_W'(1));
                    end
                end
                OP_ERASE: begin
                    if (found) begin
                        fill_next = fill_reg - CNT_W'(1);
                        m_data_next.count_at_or_below = POS_W'(le_cnt - CNT_W'(1));
                    end else begin
                        m_data_next.status = STAT_ABSENT;
                    end
                end
                OP_KTH: begin
                    if (pos_bad) m_data_next.status = STAT_RANGE;
                    else         m_data_next.kth_value = kth_raw ^ SIGN_FLIP;
                end
                OP_RANK: ;
                default: ;
            endcase
            m_data_next.occupancy = POS_W'(fill_next);
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/osm_cell.sv]
// One cell of the sorted chain: holds one entry and its compare flags.
module osm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  osm_pkg::cell_cmd_t  cmd,
    input  logic [osm_pkg::IDX_W-1:0] cell_idx,
    input  osm_pkg::cell_state_t left,
    input  osm_pkg::cell_state_t right,
    output osm_pkg::cell_state_t state
);
    import osm_pkg::*;

    logic [VAL_W-1:0] val_reg, val_next;
    logic             valid_reg, valid_next;
    logic             le_reg, le_next;
    logic             lt_reg, lt_next;
    logic [VAL_W-1:0] kpart_reg, kpart_next;

    // Compare against the request key, then shift on insert or erase.
    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        le_next    = le_reg;
        lt_next    = lt_reg;
        kpart_next = kpart_reg;
        if (cmd.eval) begin
            le_next    = valid_reg && (val_reg <= cmd.key);
            lt_next    = valid_reg && (val_reg < cmd.key);
            kpart_next = (valid_reg && (cell_idx == cmd.sel)) ? val_reg : '0;
        end else if (cmd.ins) begin
            // Entries above the key move one place up; the first of them takes the key.
            if (!le_reg) begin
                val_next   = left.le ? cmd.key : left.val;
                valid_next = valid_reg | left.valid;
            end
        end else if (cmd.del) begin
            // Entries at or above the erased one move one place down.
            if (!lt_reg) begin
                val_next   = right.val;
                valid_next = right.valid;
            end
        end
    end

    // Entry data needs no reset; valid and flags do.
    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        kpart_reg <= kpart_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            lt_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            le_reg    <= le_next;
            lt_reg    <= lt_next;
        end
    end

    always_comb begin
        state.val   = val_reg;
        state.valid = valid_reg;
        state.le    = le_reg;
        state.lt    = lt_reg;
        state.kpart = kpart_reg;
    end

endmodule
